// File: sv/ibfd_pkg.sv
package ibfd_pkg;

  // Frame layout
  localparam int unsigned NumFields     = 9;
  localparam int unsigned FieldW        = 18;
  localparam int unsigned MagW          = 17;
  localparam int unsigned PosW          = 5;
  localparam int unsigned FirstFieldPos = 4;
  localparam int unsigned LastPos       = 31;
  localparam int unsigned FieldBytes    = 3;
  localparam int unsigned StatusW       = 3;

  // Result stream packing: nine fields, status, zero fill to whole bytes
  localparam int unsigned OutBitsUsed = NumFields * FieldW + StatusW;
  localparam int unsigned OutDataW    = ((OutBitsUsed + 7) / 8) * 8;

  // Configuration register defaults and addressing
  localparam logic [7:0] StartByteReset = 8'h68;
  localparam int unsigned ApbAddrW      = 3;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_START = 3'd1,
    ST_BAD_SUM   = 3'd2,
    ST_BAD_SIGN  = 3'd3,
    ST_BAD_DIGIT = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_first;
  } in_item_t;

  typedef struct packed {
    status_e                              frame_status;
    logic [NumFields-1:0][FieldW-1:0]     fields;
  } result_t;

  // Field number for a byte offset within the field area (offset / 3)
  function automatic logic [3:0] field_index(input logic [PosW-1:0] rel);
    logic [3:0] idx;
    idx = '0;
    for (int i = 1; i < NumFields; i++) begin
      if (rel >= PosW'(i * FieldBytes)) idx = 4'(i);
    end
    return idx;
  endfunction

endpackage

// File: sv/ibfd_core.sv
module ibfd_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  ibfd_pkg::in_item_t item_i,
  input  logic [7:0]        start_byte_i,
  output logic              is_last_o,
  output ibfd_pkg::result_t res_o
);
  import ibfd_pkg::*;

  logic [PosW-1:0] pos_q, pos_d, pos;
  logic [7:0]      sum_q, sum_d;
  logic            start_bad_q, start_bad_d;
  logic            sign_bad_q, sign_bad_d;
  logic            digit_bad_q, digit_bad_d;
  logic            neg_q, neg_d;
  logic [MagW-1:0] mag_q, mag_d;
  logic [NumFields-1:0][FieldW-1:0] fields_q;

  logic [7:0]      b;
  logic [3:0]      hi, lo;
  logic [PosW-1:0] rel;
  logic [3:0]      fidx;
  logic [1:0]      k;
  logic [MagW-1:0] mag_shift;
  logic [FieldW-1:0] value;
  logic            field_wr;
  status_e         status;

  // Byte position and place within a field
  always_comb begin
    b    = item_i.rx_byte;
    hi   = b[7:4];
    lo   = b[3:0];
    pos  = item_i.frame_first ? '0 : pos_q;
    rel  = pos - PosW'(FirstFieldPos);
    fidx = field_index(rel);
    k    = 2'(rel - ((PosW'(fidx) << 1) + PosW'(fidx)));
    is_last_o = (pos == PosW'(LastPos));
  end

  // Accumulate two digits: acc*100 + hi*10 + lo, wrapping to the accumulator width
  assign mag_shift = (mag_q << 6) + (mag_q << 5) + (mag_q << 2)
                   + MagW'({hi, 3'b000}) + MagW'({hi, 1'b0}) + MagW'(lo);

  // Next state for one byte
  always_comb begin
    pos_d       = pos + 1'b1;
    sum_d       = sum_q;
    start_bad_d = start_bad_q;
    sign_bad_d  = sign_bad_q;
    digit_bad_d = digit_bad_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    field_wr    = 1'b0;
    if (pos == '0) begin
      start_bad_d = (b != start_byte_i);
      sum_d       = '0;
      sign_bad_d  = 1'b0;
      digit_bad_d = 1'b0;
    end else if (pos < PosW'(FirstFieldPos)) begin
      sum_d = sum_q + b;
    end else if (pos < PosW'(LastPos)) begin
      if (k == 2'd0) begin
        neg_d = (hi == 4'd1);
        if (hi inside {[4'd2:4'd9]}) sign_bad_d = 1'b1;
        if (lo > 4'd9) digit_bad_d = 1'b1;
        mag_d = MagW'(lo);
      end else begin
        if (hi > 4'd9 || lo > 4'd9) digit_bad_d = 1'b1;
        mag_d = mag_shift;
      end
      if (k == 2'd2) begin
        sum_d    = sum_q + b;
        field_wr = 1'b1;
      end
    end
  end

  // Signed field value from the sign flag and the finished magnitude
  assign value = neg_q ? (FieldW'(0) - {1'b0, mag_d}) : {1'b0, mag_d};

  // Frame verdict at the checksum byte, in priority order
  always_comb begin
    if (start_bad_q)        status = ST_BAD_START;
    else if (sum_q != b)    status = ST_BAD_SUM;
    else if (sign_bad_q)    status = ST_BAD_SIGN;
    else if (digit_bad_q)   status = ST_BAD_DIGIT;
    else                    status = ST_OK;
    res_o.frame_status = status;
    res_o.fields       = (status == ST_OK) ? fields_q : '0;
  end

  // Hold decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      sum_q       <= '0;
      start_bad_q <= 1'b0;
      sign_bad_q  <= 1'b0;
      digit_bad_q <= 1'b0;
      neg_q       <= 1'b0;
      mag_q       <= '0;
    end else if (step_i) begin
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      start_bad_q <= start_bad_d;
      sign_bad_q  <= sign_bad_d;
      digit_bad_q <= digit_bad_d;
      neg_q       <= neg_d;
      mag_q       <= mag_d;
    end
  end

  // Store each decoded field on its last byte
  always_ff @(posedge clk_i) begin
    if (step_i && field_wr) begin
      fields_q[fidx] <= value;
    end
  end

endmodule

// File: sv/imu_bcd_frame_decoder_unit.sv
// IMU frame decoder: takes a 32-byte frame one byte per transaction on the
// s_axis channel (tdata = received byte, tuser = first byte of a frame) and
// gives one decoded transaction on the m_axis channel after the checksum
// byte: nine signed 18-bit values and a 3-bit status. On any error the nine
// values read as zero.
// The expected start byte sits in the APB register at address 0 (0x68 after
// reset); write it only while the block is idle. pready is always high.
// One byte is taken every cycle while no checksum byte waits. A byte passes
// through an input register and then a single pass of decode logic that
// updates the frame state; the result register is loaded as the checksum
// byte leaves the input register, and the result shows on m_axis from it.
// When the receiver stalls, the result holds in its register and header and
// field bytes keep flowing; only a checksum byte waits in the input
// register, and s_axis_tready drops once that register is full.
// Reset clears the byte count, the checksum, the error flags and both valid
// flags; the first byte after reset counts as frame byte 0.
module imu_bcd_frame_decoder_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Byte stream in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
  input  logic                          s_axis_tuser,  // [0] frame_first
  // Result stream out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [17:0] angle_roll, [35:18] angle_pitch, [53:36] angle_yaw,
  // [71:54] accel_x, [89:72] accel_y, [107:90] accel_z, [125:108] rate_x,
  // [143:126] rate_y, [161:144] rate_z, [164:162] frame_status, rest zero
  output logic [ibfd_pkg::OutDataW-1:0] m_axis_tdata,
  // Configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ibfd_pkg::ApbAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import ibfd_pkg::*;

  logic       in_valid_q;
  in_item_t   in_item_q;
  logic       out_valid_q;
  result_t    out_res_q;
  logic [7:0] start_byte_q;

  logic       step;
  logic       is_last;
  logic       out_free;
  result_t    res;

  // Register write and read back
  assign pready = 1'b1;
  assign prdata = (paddr[ApbAddrW-1] == 1'b0) ? {24'd0, start_byte_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= StartByteReset;
    end else if (psel && penable && pwrite && pready && paddr[ApbAddrW-1] == 1'b0) begin
      start_byte_q <= pwdata[7:0];
    end
  end

  // Advance a byte unless it is a checksum byte facing a full result register
  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && (!is_last || out_free);
  assign s_axis_tready = !in_valid_q || step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q.rx_byte     <= s_axis_tdata;
      in_item_q.frame_first <= s_axis_tuser;
    end
  end

  ibfd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .item_i       (in_item_q),
    .start_byte_i (start_byte_q),
    .is_last_o    (is_last),
    .res_o        (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && is_last) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && is_last) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - OutBitsUsed)'(0), out_res_q};

endmodule

// File: sv/ibfd_checker.sv
module ibfd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [ibfd_pkg::OutDataW-1:0] m_axis_tdata
);
  import ibfd_pkg::*;

  localparam int unsigned FieldBits = NumFields * FieldW;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // An errored frame carries zero values
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[FieldBits +: StatusW] != ST_OK
      |-> m_axis_tdata[FieldBits-1:0] == '0)
    else $error("errored frame carries nonzero values");

  // Status code in range and fill bits zero
  a_status_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[FieldBits +: StatusW] <= ST_BAD_DIGIT
      && m_axis_tdata[OutDataW-1:OutBitsUsed] == '0)
    else $error("bad status code or fill bits");

  // Input backpressure only while the result side stalls
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with result side free");

endmodule

bind imu_bcd_frame_decoder_unit ibfd_checker u_ibfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: tb/tb_imu_bcd_frame_decoder_unit.sv
module tb_imu_bcd_frame_decoder_unit;
  import ibfd_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam logic [ApbAddrW-1:0] RegStartAddr = '0;

  typedef enum {
    FK_GOOD, FK_HEX_SIGN, FK_BAD_START, FK_BAD_SUM, FK_BAD_SIGN, FK_BAD_DIGIT, FK_MIXED
  } frame_kind_e;

  typedef enum {VM_RANDOM, VM_EDGE, VM_MAX, VM_ZERO} value_mix_e;

  // Expected decode of the byte stream, one entry per checksum byte
  class frame_scoreboard;
    logic [7:0]        start_value;
    logic [PosW-1:0]   byte_pos;
    logic [7:0]        chk_sum;
    bit                start_err, sign_err, digit_err, neg;
    logic [MagW-1:0]   mag;
    logic [FieldW-1:0] decoded [NumFields];
    result_t           expected_frames [$];
    int unsigned       n_expected, n_results, n_bad_frames, n_errors;
    string field_label [NumFields] = '{"angle_roll", "angle_pitch", "angle_yaw",
                                       "accel_x", "accel_y", "accel_z",
                                       "rate_x", "rate_y", "rate_z"};

    function new();
      start_value = StartByteReset;
      byte_pos    = '0;
      chk_sum     = '0;
      start_err   = 1'b0;
      sign_err    = 1'b0;
      digit_err   = 1'b0;
      neg         = 1'b0;
      mag         = '0;
      foreach (decoded[i]) decoded[i] = '0;
    endfunction

    // Fold one decimal digit into the magnitude, wrapping to its width
    function void add_digit(logic [3:0] d);
      if (d > 4'd9) digit_err = 1'b1;
      mag = MagW'(mag * 10 + d);
    endfunction

    // Advance the frame state by one accepted byte
    function void note_byte(logic [7:0] b, bit first);
      int unsigned rel, fidx, k;
      logic [FieldW-1:0] m18;
      status_e st;
      result_t r;
      if (first) byte_pos = '0;
      if (byte_pos == 0) begin
        start_err = (b != start_value);
        chk_sum   = '0;
        sign_err  = 1'b0;
        digit_err = 1'b0;
      end else if (byte_pos < FirstFieldPos) begin
        chk_sum = chk_sum + b;
      end else if (byte_pos < LastPos) begin
        rel  = byte_pos - FirstFieldPos;
        fidx = rel / FieldBytes;
        k    = rel % FieldBytes;
        if (k == 0) begin
          neg = (b[7:4] == 4'd1);
          if (b[7:4] >= 4'd2 && b[7:4] <= 4'd9) sign_err = 1'b1;
          mag = '0;
          add_digit(b[3:0]);
        end else begin
          add_digit(b[7:4]);
          add_digit(b[3:0]);
        end
        if (k == 2) begin
          m18 = {1'b0, mag};
          decoded[fidx] = neg ? (~m18 + 1'b1) : m18;
          chk_sum = chk_sum + b;
        end
      end else begin
        if (start_err)          st = ST_BAD_START;
        else if (chk_sum != b)  st = ST_BAD_SUM;
        else if (sign_err)      st = ST_BAD_SIGN;
        else if (digit_err)     st = ST_BAD_DIGIT;
        else                    st = ST_OK;
        r.frame_status = st;
        for (int i = 0; i < NumFields; i++) r.fields[i] = (st == ST_OK) ? decoded[i] : '0;
        expected_frames.push_back(r);
        n_expected++;
      end
      byte_pos = byte_pos + 1'b1;
    endfunction

    // Compare one result transaction with the oldest expected frame
    function void check_result(logic [OutDataW-1:0] data);
      result_t got, want;
      got = result_t'(data[OutBitsUsed-1:0]);
      n_results++;
      if (expected_frames.size() == 0) begin
        $display("%0t: result with nothing pending, status %0d", $time, got.frame_status);
        n_errors++;
        return;
      end
      want = expected_frames.pop_front();
      if (want.frame_status != ST_OK) n_bad_frames++;
      if (got.frame_status !== want.frame_status) begin
        $display("%0t: frame_status expected %0d, got %0d", $time,
                 want.frame_status, got.frame_status);
        n_errors++;
      end
      for (int i = 0; i < NumFields; i++) begin
        if (got.fields[i] !== want.fields[i]) begin
          $display("%0t: %s expected %0d, got %0d", $time, field_label[i],
                   $signed(want.fields[i]), $signed(got.fields[i]));
          n_errors++;
        end
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;  // [7:0] rx_byte
  logic                s_axis_tuser  = 1'b0;  // [0] frame_first
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;  // nine 18-bit fields from bit 0, status, zero fill
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [ApbAddrW-1:0] paddr         = '0;
  logic [31:0]         pwdata        = '0;
  logic [31:0]         prdata;
  logic                pready;

  frame_scoreboard sb;
  bit              calm        = 1'b0;
  int unsigned     n_bytes     = 0;
  int unsigned     out_wait    = 0;
  int unsigned     cycle_count = 0;

  imu_bcd_frame_decoder_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Stop a hung run
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("timeout after %0d cycles", cycle_count);
    $display("RESULT: ERROR");
    $finish;
  end

  // Take results, stalling at random after each one and now and then while idle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata);
        out_wait = calm ? 0 : $urandom_range(0, 8);
      end else if (out_wait != 0) begin
        out_wait--;
      end else if (!calm && !m_axis_tvalid && $urandom_range(0, 7) == 0) begin
        out_wait = $urandom_range(1, 8);
      end
      m_axis_tready <= (out_wait == 0);
    end
  end

  // Offer one byte after a random gap and hold it until accepted
  task automatic push_byte(input logic [7:0] b, input bit first);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= first;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(b, first);
    n_bytes++;
  endtask

  task automatic send_noise(input int unsigned count);
    repeat (count) push_byte(8'($urandom), $urandom_range(0, 7) == 0);
  endtask

  // Build a frame of the given kind and send its first len bytes
  task automatic send_frame(input frame_kind_e kind, input value_mix_e vm,
                            input bit first_flag, input int unsigned len);
    logic [7:0]  fb [32];
    logic [3:0]  dig [5];
    logic [3:0]  sgn, bad;
    logic [7:0]  sum;
    int unsigned value, div, victim, nib;
    bit          neg, do_start, do_sign, do_digit, do_sum;
    do_start = (kind == FK_BAD_START) || (kind == FK_MIXED && $urandom_range(0, 1) == 1);
    do_sign  = (kind == FK_BAD_SIGN) || (kind == FK_MIXED);
    do_digit = (kind == FK_BAD_DIGIT) || (kind == FK_MIXED);
    do_sum   = (kind == FK_BAD_SUM) || (kind == FK_MIXED && $urandom_range(0, 1) == 1);
    // header: start, length, address, command
    fb[0] = do_start ? (sb.start_value ^ 8'($urandom_range(1, 255))) : sb.start_value;
    fb[1] = 8'($urandom);
    fb[2] = 8'($urandom);
    fb[3] = 8'($urandom);
    // sign nibble and five decimal digits per field
    for (int f = 0; f < NumFields; f++) begin
      case (vm)
        VM_MAX:  value = 99999;
        VM_ZERO: value = 0;
        VM_EDGE: begin
          case ($urandom_range(0, 4))
            0:       value = 0;
            1:       value = 1;
            2:       value = 99999;
            3:       value = $urandom_range(0, 9) * 11111;
            default: value = $urandom_range(0, 99999);
          endcase
        end
        default: value = $urandom_range(0, 99999);
      endcase
      neg = (vm == VM_MAX || vm == VM_ZERO) ? ((f % 2) == 1) : ($urandom_range(0, 1) == 1);
      sgn = neg ? 4'h1 : 4'h0;
      if (!neg && kind == FK_HEX_SIGN && $urandom_range(0, 1) == 1)
        sgn = 4'($urandom_range(10, 15));
      div = 10000;
      for (int d = 0; d < 5; d++) begin
        dig[d] = 4'((value / div) % 10);
        div = div / 10;
      end
      fb[4 + 3*f] = {sgn, dig[0]};
      fb[5 + 3*f] = {dig[1], dig[2]};
      fb[6 + 3*f] = {dig[3], dig[4]};
    end
    if (do_sign) begin
      victim = $urandom_range(0, NumFields - 1);
      fb[4 + 3*victim][7:4] = 4'($urandom_range(2, 9));
    end
    if (do_digit) begin
      victim = $urandom_range(0, NumFields - 1);
      if ($urandom_range(0, 3) == 0) begin
        // all digits F, so the magnitude wraps as well
        fb[4 + 3*victim][3:0] = 4'hF;
        fb[5 + 3*victim]      = 8'hFF;
        fb[6 + 3*victim]      = 8'hFF;
      end else begin
        nib = $urandom_range(0, 4);
        bad = 4'($urandom_range(10, 15));
        case (nib)
          0:       fb[4 + 3*victim][3:0] = bad;
          1:       fb[5 + 3*victim][7:4] = bad;
          2:       fb[5 + 3*victim][3:0] = bad;
          3:       fb[6 + 3*victim][7:4] = bad;
          default: fb[6 + 3*victim][3:0] = bad;
        endcase
      end
    end
    // checksum over the header bytes after the start byte and the last byte of each field
    sum = fb[1] + fb[2] + fb[3];
    for (int f = 0; f < NumFields; f++) sum = sum + fb[6 + 3*f];
    fb[31] = do_sum ? (sum + 8'($urandom_range(1, 255))) : sum;
    for (int i = 0; i < len; i++) push_byte(fb[i], (i == 0) && first_flag);
  endtask

  // Drain, let the pipeline settle, write the start byte and read it back
  task automatic write_start_byte(input logic [7:0] v);
    logic [31:0] rd;
    s_axis_tvalid <= 1'b0;
    while (sb.expected_frames.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= RegStartAddr;
    pwdata  <= {24'h0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.start_value = v;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    rd = prdata;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[7:0] !== v) begin
      $display("%0t: start byte read back expected %0d, got %0d", $time, v, rd[7:0]);
      sb.n_errors++;
    end
  endtask

  // Mostly well-formed frames, with noise and cut-short frames between them
  task automatic random_phase(input int unsigned byte_goal, input int unsigned result_goal);
    int unsigned b0, r0, pick;
    frame_kind_e kind;
    value_mix_e  vm;
    b0 = n_bytes;
    r0 = sb.n_expected;
    while ((n_bytes - b0) < byte_goal || (sb.n_expected - r0) < result_goal) begin
      calm = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 19);
      if (pick == 0) send_noise($urandom_range(1, 12));
      else if (pick == 1) send_frame(FK_GOOD, VM_RANDOM, 1'b1, $urandom_range(1, 31));
      pick = $urandom_range(0, 19);
      case (pick)
        0, 1:    kind = FK_HEX_SIGN;
        2, 3:    kind = FK_BAD_START;
        4, 5:    kind = FK_BAD_SUM;
        6:       kind = FK_BAD_SIGN;
        7:       kind = FK_BAD_DIGIT;
        8:       kind = FK_MIXED;
        default: kind = FK_GOOD;
      endcase
      vm = ($urandom_range(0, 3) == 0) ? VM_EDGE : VM_RANDOM;
      send_frame(kind, vm, (sb.byte_pos != 0) || ($urandom_range(0, 1) == 1), 32);
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames under the reset start byte
    send_frame(FK_GOOD, VM_MAX, 1'b1, 32);
    send_frame(FK_GOOD, VM_ZERO, 1'b0, 32);     // starts by count wrap alone
    send_frame(FK_HEX_SIGN, VM_EDGE, 1'b1, 32);
    send_frame(FK_BAD_START, VM_EDGE, 1'b1, 32);
    send_frame(FK_BAD_SUM, VM_EDGE, 1'b1, 32);
    send_frame(FK_BAD_SIGN, VM_EDGE, 1'b1, 32);
    send_frame(FK_BAD_DIGIT, VM_EDGE, 1'b1, 32);
    send_frame(FK_MIXED, VM_EDGE, 1'b1, 32);
    send_frame(FK_GOOD, VM_RANDOM, 1'b1, 17);   // cut short, restarted below
    send_frame(FK_GOOD, VM_EDGE, 1'b1, 32);
    send_noise(6);
    send_frame(FK_GOOD, VM_RANDOM, 1'b1, 32);

    // random frames under several start bytes, the extremes among them
    write_start_byte(8'h00);
    random_phase(180, 6);
    write_start_byte(8'hFF);
    random_phase(180, 6);
    write_start_byte(8'($urandom_range(1, 254)));
    random_phase(180, 6);
    write_start_byte(StartByteReset);
    random_phase(180, 6);

    // wait for the last results, then for anything stray
    s_axis_tvalid <= 1'b0;
    while (sb.expected_frames.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("sent %0d bytes over five start byte settings; checked %0d results",
             n_bytes, sb.n_results);
    $display("%0d results carried an error status, %0d mismatches", sb.n_bad_frames,
             sb.n_errors);
    if (sb.n_errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
